@@ design/bezier_curve_point_eval_unit_defines.svh @@
// Assertion macros for the Bezier curve point evaluator.
// Included by the checker module; relies on clk_i and rst_ni in scope.
`ifndef BEZIER_CURVE_POINT_EVAL_UNIT_DEFINES_SVH
`define BEZIER_CURVE_POINT_EVAL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bcpe_pkg.sv @@
// Shared constants and types for the Bezier curve point evaluator.
// No dependencies; imported by the weight, MAC, round and top-level modules.
`default_nettype none

package bcpe_pkg;

  // Curve and number format.
  localparam int unsigned MAX_DEGREE  = 3;
  localparam int unsigned NUM_POINTS  = MAX_DEGREE + 1;
  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned IN_BITS     = FRAC_BITS + 2;
  localparam int unsigned T_BITS      = FRAC_BITS + 1;
  localparam int unsigned SQ_BITS     = 2 * T_BITS;
  localparam int unsigned TRI_BITS    = T_BITS + 2;
  localparam int unsigned CUBE_BITS   = SQ_BITS + T_BITS;
  localparam int unsigned MIX_BITS    = SQ_BITS + TRI_BITS;

  // Weights are all scaled to 2^(FRAC_BITS * MAX_DEGREE) whatever the degree.
  localparam int unsigned ROUND_SHIFT = MAX_DEGREE * FRAC_BITS;
  localparam int unsigned W_BITS      = ROUND_SHIFT + 1;
  localparam int unsigned W_LO_BITS   = 24;
  localparam int unsigned W_HI_BITS   = W_BITS - W_LO_BITS;
  localparam int unsigned PL_BITS     = COORD_BITS + W_LO_BITS + 1;
  localparam int unsigned PH_BITS     = COORD_BITS + W_HI_BITS + 1;
  localparam int unsigned ACC_BITS    = COORD_BITS + W_BITS + 1;
  localparam int unsigned Q_BITS      = ACC_BITS - ROUND_SHIFT;

  localparam logic [IN_BITS-1:0]  T_ONE     = IN_BITS'(1) << FRAC_BITS;
  localparam logic [ACC_BITS-1:0] ROUND_ADD = ACC_BITS'(1) << (ROUND_SHIFT - 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 2 * COORD_BITS;
  localparam int unsigned DEG_BITS      = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEGREE      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_POINT_ZERO  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_POINT_ONE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_POINT_TWO   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_POINT_THREE = 3'd4;

  localparam logic [DEG_BITS-1:0] DEGREE_RESET = DEG_BITS'(MAX_DEGREE);

  typedef logic [DEG_BITS-1:0] degree_t;
  typedef logic [NUM_POINTS-1:0][CFG_DATA_BITS-1:0] points_t;

  // Powers of t and u = 1 - t after the first stage.
  typedef struct packed {
    logic                exists;
    degree_t             degree;
    logic [T_BITS-1:0]   t;
    logic [T_BITS-1:0]   u;
    logic [SQ_BITS-1:0]  uu;
    logic [SQ_BITS-1:0]  ut;
    logic [SQ_BITS-1:0]  tt;
    logic [TRI_BITS-1:0] t3;
    logic [TRI_BITS-1:0] u3;
  } pow_t;

  // Bernstein weights, one per control point.
  typedef struct packed {
    logic                             exists;
    logic [NUM_POINTS-1:0][W_BITS-1:0] w;
  } wt_t;

  // Pair sums of weighted control points.
  typedef struct packed {
    logic                      exists;
    logic [ACC_BITS-1:0]       x_lo;
    logic [ACC_BITS-1:0]       x_hi;
    logic [ACC_BITS-1:0]       y_lo;
    logic [ACC_BITS-1:0]       y_hi;
  } psum_t;

endpackage

`default_nettype wire

@@ design/bcpe_weight.sv @@
// Two pipeline stages that turn t into the Bernstein weights of the curve.
// Depends on bcpe_pkg.
`default_nettype none

module bcpe_weight
  import bcpe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic [IN_BITS-1:0] t_param_i,
  input  wire degree_t            degree_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output wt_t                     wt_o
);

  logic v1_q, v2_q;
  logic en1, en2;
  pow_t s1_d, s1_q;
  wt_t  s2_d, s2_q;

  logic                 in_range;
  logic [T_BITS-1:0]    t_val, u_val;
  logic [CUBE_BITS-1:0] uuu, ttt;
  logic [MIX_BITS-1:0]  uut3, ttu3;

  // A stage moves on when it is empty or the next one moves on.
  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;
  assign wt_o    = s2_q;

  // Stage one: range check, u = 1 - t, squares and triples.
  always_comb begin
    in_range = !t_param_i[IN_BITS-1] && (t_param_i <= T_ONE);
    t_val    = in_range ? t_param_i[T_BITS-1:0] : '0;
    // Out of range zeroes both t and u, so every weight and the point come out zero.
    u_val    = in_range ? (T_ONE[T_BITS-1:0] - t_val) : '0;

    s1_d.exists = in_range;
    // A degree of zero behaves as degree one.
    s1_d.degree = (degree_i == '0) ? DEG_BITS'(1) : degree_i;
    s1_d.t      = t_val;
    s1_d.u      = u_val;
    s1_d.uu     = SQ_BITS'(u_val) * SQ_BITS'(u_val);
    s1_d.ut     = SQ_BITS'(u_val) * SQ_BITS'(t_val);
    s1_d.tt     = SQ_BITS'(t_val) * SQ_BITS'(t_val);
    s1_d.t3     = TRI_BITS'(t_val) + TRI_BITS'({t_val, 1'b0});
    s1_d.u3     = TRI_BITS'(u_val) + TRI_BITS'({u_val, 1'b0});
  end

  // Stage two: cubic terms, then weights scaled to the common fraction width.
  always_comb begin
    uuu  = CUBE_BITS'(s1_q.uu) * CUBE_BITS'(s1_q.u);
    ttt  = CUBE_BITS'(s1_q.tt) * CUBE_BITS'(s1_q.t);
    uut3 = MIX_BITS'(s1_q.uu) * MIX_BITS'(s1_q.t3);
    ttu3 = MIX_BITS'(s1_q.tt) * MIX_BITS'(s1_q.u3);

    s2_d.exists = s1_q.exists;
    case (s1_q.degree)
      2'd3: begin
        s2_d.w[0] = uuu[W_BITS-1:0];
        s2_d.w[1] = uut3[W_BITS-1:0];
        s2_d.w[2] = ttu3[W_BITS-1:0];
        s2_d.w[3] = ttt[W_BITS-1:0];
      end
      2'd2: begin
        s2_d.w[0] = W_BITS'({s1_q.uu, {FRAC_BITS{1'b0}}});
        s2_d.w[1] = W_BITS'({s1_q.ut, {(FRAC_BITS + 1){1'b0}}});
        s2_d.w[2] = W_BITS'({s1_q.tt, {FRAC_BITS{1'b0}}});
        s2_d.w[3] = '0;
      end
      default: begin
        s2_d.w[0] = W_BITS'({s1_q.u, {(2 * FRAC_BITS){1'b0}}});
        s2_d.w[1] = W_BITS'({s1_q.t, {(2 * FRAC_BITS){1'b0}}});
        s2_d.w[2] = '0;
        s2_d.w[3] = '0;
      end
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
  end

endmodule

`default_nettype wire

@@ design/bcpe_mac.sv @@
// Three pipeline stages that weight the control points and form pair sums.
// Depends on bcpe_pkg.
`default_nettype none

module bcpe_mac
  import bcpe_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  wire wt_t     wt_i,
  input  wire points_t points_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output psum_t        psum_o
);

  logic v3_q, v4_q, v5_q;
  logic en3, en4, en5;
  logic ex3_q, ex4_q;

  logic signed [PL_BITS-1:0]  plx_d [NUM_POINTS];
  logic signed [PL_BITS-1:0]  ply_d [NUM_POINTS];
  logic signed [PH_BITS-1:0]  phx_d [NUM_POINTS];
  logic signed [PH_BITS-1:0]  phy_d [NUM_POINTS];
  logic signed [PL_BITS-1:0]  plx_q [NUM_POINTS];
  logic signed [PL_BITS-1:0]  ply_q [NUM_POINTS];
  logic signed [PH_BITS-1:0]  phx_q [NUM_POINTS];
  logic signed [PH_BITS-1:0]  phy_q [NUM_POINTS];
  logic signed [ACC_BITS-1:0] px_d  [NUM_POINTS];
  logic signed [ACC_BITS-1:0] py_d  [NUM_POINTS];
  logic signed [ACC_BITS-1:0] px_q  [NUM_POINTS];
  logic signed [ACC_BITS-1:0] py_q  [NUM_POINTS];
  psum_t                      s5_d, s5_q;

  assign en5     = !v5_q || ready_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign ready_o = en3;
  assign valid_o = v5_q;
  assign psum_o  = s5_q;

  // Stage three: each weight is split in two halves so that no multiplier
  // is wider than the coordinate times half a weight.
  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      logic signed [COORD_BITS-1:0] cx, cy;
      logic signed [W_LO_BITS:0]    wl;
      logic signed [W_HI_BITS:0]    wh;
      cx = points_i[i][COORD_BITS-1:0];
      cy = points_i[i][2*COORD_BITS-1:COORD_BITS];
      wl = {1'b0, wt_i.w[i][W_LO_BITS-1:0]};
      wh = {1'b0, wt_i.w[i][W_BITS-1:W_LO_BITS]};
      plx_d[i] = cx * wl;
      ply_d[i] = cy * wl;
      phx_d[i] = cx * wh;
      phy_d[i] = cy * wh;
    end
  end

  // Stage four: put the halves back together.
  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      px_d[i] = (ACC_BITS'(phx_q[i]) <<< W_LO_BITS) + ACC_BITS'(plx_q[i]);
      py_d[i] = (ACC_BITS'(phy_q[i]) <<< W_LO_BITS) + ACC_BITS'(ply_q[i]);
    end
  end

  // Stage five: pair sums.
  always_comb begin
    s5_d.exists = ex4_q;
    s5_d.x_lo   = px_q[0] + px_q[1];
    s5_d.x_hi   = px_q[2] + px_q[3];
    s5_d.y_lo   = py_q[0] + py_q[1];
    s5_d.y_hi   = py_q[2] + py_q[3];
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en3) v3_q <= valid_i;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en3) begin
      ex3_q <= wt_i.exists;
      plx_q <= plx_d;
      ply_q <= ply_d;
      phx_q <= phx_d;
      phy_q <= phy_d;
    end
    if (en4) begin
      ex4_q <= ex3_q;
      px_q  <= px_d;
      py_q  <= py_d;
    end
    if (en5) s5_q <= s5_d;
  end

endmodule

`default_nettype wire

@@ design/bcpe_round.sv @@
// Final sum with rounding offset, then shift, saturation and output register.
// Depends on bcpe_pkg.
`default_nettype none

module bcpe_round
  import bcpe_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire psum_t              psum_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [COORD_BITS-1:0]   x_coord_o,
  output logic [COORD_BITS-1:0]   y_coord_o,
  output logic                    exists_o
);

  logic v6_q, v7_q;
  logic en6, en7;
  logic ex6_q, ex7_q;
  logic [ACC_BITS-1:0]   accx_d, accy_d, accx_q, accy_q;
  logic [COORD_BITS-1:0] x_d, y_d, x_q, y_q;

  // Clamp an integer part to the signed coordinate range.
  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [Q_BITS-1:0] q);
    logic [Q_BITS-COORD_BITS:0] top;
    top = q[Q_BITS-1:COORD_BITS-1];
    if ((&top) || !(|top)) begin
      sat_coord = q[COORD_BITS-1:0];
    end else if (q[Q_BITS-1]) begin
      sat_coord = {1'b1, {(COORD_BITS - 1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_BITS - 1){1'b1}}};
    end
  endfunction

  assign en7       = !v7_q || ready_i;
  assign en6       = !v6_q || en7;
  assign ready_o   = en6;
  assign valid_o   = v7_q;
  assign x_coord_o = x_q;
  assign y_coord_o = y_q;
  assign exists_o  = ex7_q;

  // Stage six: full sum plus half an output step, so the shift rounds to
  // nearest with ties going up.
  assign accx_d = psum_i.x_lo + psum_i.x_hi + ROUND_ADD;
  assign accy_d = psum_i.y_lo + psum_i.y_hi + ROUND_ADD;

  // Stage seven: drop the fraction (arithmetic shift) and saturate.
  assign x_d = sat_coord(accx_q[ACC_BITS-1:ROUND_SHIFT]);
  assign y_d = sat_coord(accy_q[ACC_BITS-1:ROUND_SHIFT]);

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en6) v6_q <= valid_i;
      if (en7) v7_q <= v6_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en6) begin
      ex6_q  <= psum_i.exists;
      accx_q <= accx_d;
      accy_q <= accy_d;
    end
    if (en7) begin
      ex7_q <= ex6_q;
      x_q   <= x_d;
      y_q   <= y_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bezier_curve_point_eval_unit.sv @@
// Bezier curve point evaluator: an accepted item passes through the
// seven-stage pipeline (powers, weights, split products, product merge,
// pair sums, final sum, round) to its result on the output register.
// Throughput is one item per clock while the output is not stalled; each stage holds its item only while the
// next one is full and stalled, so bubbles close up under backpressure.
// Reset clears all valid bits and sets degree 3 with all control points zero.
`default_nettype none

module bezier_curve_point_eval_unit
  import bcpe_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Configuration writes.
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  // Input items.
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [23:0]              s_axis_tdata,  // [17:0] t_param, rest zero
  // Result items.
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [15:0] x_coord, [31:16] y_coord
  output logic                          m_axis_tuser   // [0] exists
);

  degree_t degree_q;
  points_t points_q;

  logic  wt_valid, wt_ready, ps_valid, ps_ready;
  wt_t   wt;
  psum_t psum;
  logic [COORD_BITS-1:0] x_coord, y_coord;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEGREE_RESET;
      points_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEGREE:      degree_q    <= cfg_data_i[DEG_BITS-1:0];
        REG_POINT_ZERO:  points_q[0] <= cfg_data_i;
        REG_POINT_ONE:   points_q[1] <= cfg_data_i;
        REG_POINT_TWO:   points_q[2] <= cfg_data_i;
        REG_POINT_THREE: points_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bcpe_weight u_weight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .t_param_i (s_axis_tdata[IN_BITS-1:0]),
    .degree_i  (degree_q),
    .valid_o   (wt_valid),
    .ready_i   (wt_ready),
    .wt_o      (wt)
  );

  bcpe_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (wt_valid),
    .ready_o  (wt_ready),
    .wt_i     (wt),
    .points_i (points_q),
    .valid_o  (ps_valid),
    .ready_i  (ps_ready),
    .psum_o   (psum)
  );

  bcpe_round u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (ps_valid),
    .ready_o   (ps_ready),
    .psum_i    (psum),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .x_coord_o (x_coord),
    .y_coord_o (y_coord),
    .exists_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {y_coord, x_coord};

endmodule

`default_nettype wire

@@ design/bcpe_checker.sv @@
// Port-level checks for the Bezier curve point evaluator, bound to the top level.
// Depends on the assertion macros in bezier_curve_point_eval_unit_defines.svh.
`default_nettype none

`include "bezier_curve_point_eval_unit_defines.svh"

module bcpe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic        out_stall;
  logic        out_absent;
  logic [32:0] out_item;

  // Output side conditions used by the checks below.
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_absent = m_axis_tvalid && !m_axis_tuser;
  assign out_item   = {m_axis_tuser, m_axis_tdata};

  // A result offered but not taken stays offered.
  `BCPE_ASSERT_NXT(a_out_valid_hold, out_stall, m_axis_tvalid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `BCPE_ASSERT_NXT(a_out_data_hold, out_stall, $stable(out_item), "result changed while stalled")

  // With the output register empty, every stage can move, so input is taken.
  `BCPE_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input refused when empty")

  // A parameter outside the curve gives a zero point.
  `BCPE_ASSERT_IMP(a_zero_when_absent, out_absent, m_axis_tdata == 32'd0, "point without exists")

endmodule

bind bezier_curve_point_eval_unit bcpe_checker u_bcpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
